@@ hdl/rhsp_pkg.sv @@
package rhsp_pkg;

    localparam int DEF_SECTOR_BYTES = 512;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_ID_LEN       = 32;
    localparam int DEF_COORD_LEN    = 16;
    localparam int DEF_NAME_LEN     = 16;
    localparam int DEF_COMMENT_LEN  = 256;

    localparam int MAX_RES = 4;

    typedef enum logic [1:0] {
        MODE_TAG    = 2'd0,
        MODE_BODY   = 2'd1,
        MODE_SKIP   = 2'd2,
        MODE_PREFIX = 2'd3
    } mode_t;

    localparam logic [3:0] STEP_TIME = 4'd0;
    localparam logic [3:0] STEP_SYNC = 4'd1;
    localparam logic [3:0] STEP_ADDR = 4'd2;
    localparam logic [3:0] STEP_CHAN = 4'd6;
    localparam logic [3:0] STEP_GAIN = 4'd7;
    localparam logic [3:0] STEP_BITD = 4'd8;
    localparam logic [3:0] STEP_RCID = 4'd9;
    localparam logic [3:0] STEP_LOGI = 4'd12;
    localparam logic [3:0] STEP_ALIA = 4'd13;
    localparam logic [3:0] STEP_CMNT = 4'd14;
    localparam logic [3:0] STEP_END  = 4'd15;

    localparam logic [4:0] K_VERSION  = 5'd0;
    localparam logic [4:0] K_SYNCTYPE = 5'd2;
    localparam logic [4:0] K_SYNCTIME = 5'd3;
    localparam logic [4:0] K_SKEW     = 5'd4;
    localparam logic [4:0] K_GAIN     = 5'd10;
    localparam logic [4:0] K_STR_OFS  = 5'd3;
    localparam logic [4:0] K_FINAL    = 5'd18;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LAST_NZ  = 3'd1;
    localparam logic [2:0] ST_TAG      = 3'd2;
    localparam logic [2:0] ST_PAST_END = 3'd3;
    localparam logic [2:0] ST_CHANS    = 3'd4;
    localparam logic [2:0] ST_STR_LONG = 3'd5;

    localparam logic [1:0] SYNC_NONE = 2'd0;
    localparam logic [1:0] SYNC_SYNC = 2'd1;
    localparam logic [1:0] SYNC_SKEW = 2'd2;

    localparam logic [31:0] TAG_SYNC = 32'h73796E63;
    localparam logic [31:0] TAG_SKEW = 32'h736B6577;

    typedef struct packed {
        logic [4:0]  field_kind;
        logic [63:0] value;
        logic [8:0]  item_index;
        logic [7:0]  channel_index;
        logic [2:0]  status;
        logic        last_of_sector;
    } res_t;

    function automatic res_t mk_res(logic [4:0] kind, logic [63:0] val,
                                    logic [8:0] idx, logic [7:0] ch);
        res_t r;
        r.field_kind     = kind;
        r.value          = val;
        r.item_index     = idx;
        r.channel_index  = ch;
        r.status         = ST_OK;
        r.last_of_sector = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] prefix_byte(logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = 8'h36;
            2'd1:    r = 8'h44;
            2'd2:    r = 8'h36;
            default: r = 8'h02;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] tag_char(logic [3:0] step, logic [1:0] i);
        logic [31:0] t;
        unique case (step)
            4'd0:    t = "time";
            4'd2:    t = "addr";
            4'd3:    t = "rate";
            4'd4:    t = "writ";
            4'd5:    t = "lost";
            4'd6:    t = "chan";
            4'd7:    t = "gain";
            4'd8:    t = "bitd";
            4'd9:    t = "rcid";
            4'd10:   t = "rtci";
            4'd11:   t = "lati";
            4'd12:   t = "logi";
            4'd13:   t = "alia";
            4'd14:   t = "cmnt";
            default: t = "----";
        endcase
        return t[8*(3-i) +: 8];
    endfunction

    function automatic logic [3:0] num_len(logic [3:0] step);
        logic [3:0] r;
        unique case (step)
            4'd0:    r = 4'd6;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd2;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd4;
            4'd6:    r = 4'd1;
            4'd8:    r = 4'd1;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] num_kind(logic [3:0] step);
        logic [4:0] r;
        unique case (step)
            4'd0:    r = 5'd1;
            4'd2:    r = 5'd5;
            4'd3:    r = 5'd6;
            4'd4:    r = 5'd7;
            4'd5:    r = 5'd8;
            4'd6:    r = 5'd9;
            4'd8:    r = 5'd11;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/rhsp_if.sv @@
interface rhsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       sector_start;
    modport source (output valid, output data_byte, output sector_start, input ready);
    modport sink   (input valid, input data_byte, input sector_start, output ready);
endinterface

interface rhsp_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_kind;
    logic [63:0] value;
    logic [8:0]  item_index;
    logic [7:0]  channel_index;
    logic [2:0]  status;
    logic        last_of_sector;
    modport source (output valid, output field_kind, output value, output item_index,
                    output channel_index, output status, output last_of_sector,
                    input ready);
    modport sink   (input valid, input field_kind, input value, input item_index,
                    input channel_index, input status, input last_of_sector,
                    output ready);
endinterface

@@ hdl/recorder_header_sector_parser_unit.sv @@
// Recorder header sector parser.
// byte_in: one sector byte per request, offset 0 first; sector_start high
// restarts parsing with that byte as offset 0.
// field_out: decoded fields as kind/value/index requests; strings give one
// request per character, the sync block three, and the byte at offset
// SECTOR_BYTES-1 always adds a final status request with last_of_sector set.
// Latency: results of a byte are offered the cycle after it is accepted.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver takes each one; a byte yielding more results holds the
// input off while they drain from the result bundle register.
// A new byte is accepted in the same cycle the last pending result leaves.
// Reset: parser returns to offset 0 expecting version prefix or time tag,
// no results pending. A stalled receiver holds the pending result stable
// and back-pressures byte_in while any result is pending.
module recorder_header_sector_parser_unit #(
    parameter int SECTOR_BYTES = rhsp_pkg::DEF_SECTOR_BYTES,
    parameter int MAX_CHANNELS = rhsp_pkg::DEF_MAX_CHANNELS,
    parameter int ID_LEN       = rhsp_pkg::DEF_ID_LEN,
    parameter int COORD_LEN    = rhsp_pkg::DEF_COORD_LEN,
    parameter int NAME_LEN     = rhsp_pkg::DEF_NAME_LEN,
    parameter int COMMENT_LEN  = rhsp_pkg::DEF_COMMENT_LEN
) (
    input  logic              clk,
    input  logic              rst_n,
    rhsp_in_if.sink           byte_in,
    rhsp_out_if.source        field_out
);
    import rhsp_pkg::*;

    localparam int OFF_W = $clog2(SECTOR_BYTES);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(SECTOR_BYTES - 1);

    logic [OFF_W-1:0] off_reg,  off_next;
    logic [3:0]       step_reg, step_next;
    mode_t            mode_reg, mode_next;
    logic [8:0]       fbc_reg,  fbc_next;
    logic [63:0]      acc_reg,  acc_next;
    logic [47:0]      sts_reg,  sts_next;
    logic [1:0]       sk_reg,   sk_next;
    logic             bok_reg,  bok_next;
    logic [7:0]       ctot_reg, ctot_next;
    logic [7:0]       ccnt_reg, ccnt_next;
    logic [2:0]       err_reg,  err_next;

    res_t             res_reg [MAX_RES];
    res_t             res_next [MAX_RES];
    logic [2:0]       cnt_reg, n_res;
    logic [1:0]       pos_reg;

    logic [7:0]       b;
    logic             last_byte, done;
    logic [2:0]       final_st;
    logic [9:0]       str_size;
    logic             take, last_take, accept;

    always_comb
    begin
        b = byte_in.data_byte;
        if (byte_in.sector_start)
        begin
            off_next = '0; step_next = STEP_TIME; mode_next = MODE_TAG; fbc_next = '0;
            acc_next = '0; sts_next = '0; sk_next = SYNC_NONE; bok_next = 1'b1;
            ctot_next = '0; ccnt_next = '0; err_next = ST_OK;
        end
        else
        begin
            off_next = off_reg; step_next = step_reg; mode_next = mode_reg;
            fbc_next = fbc_reg; acc_next = acc_reg; sts_next = sts_reg;
            sk_next = sk_reg; bok_next = bok_reg; ctot_next = ctot_reg;
            ccnt_next = ccnt_reg; err_next = err_reg;
        end
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_next[i] = '0;
        end
        n_res     = '0;
        done      = 1'b0;
        final_st  = ST_OK;
        last_byte = (off_next >= OFF_LAST);

        if (step_next <= 4'd10)
            str_size = 10'(ID_LEN);
        else if (step_next <= STEP_LOGI)
            str_size = 10'(COORD_LEN);
        else if (step_next == STEP_ALIA)
            str_size = 10'(NAME_LEN);
        else
            str_size = 10'(COMMENT_LEN);

        if ((last_byte && b != 8'd0) || step_next >= STEP_END)
            done = 1'b1;

        if (!done && mode_next == MODE_PREFIX)
        begin
            done = 1'b1;
            if (b != prefix_byte(fbc_next[1:0]))
            begin
                if (err_next == ST_OK) err_next = ST_TAG;
                step_next = STEP_END; mode_next = MODE_TAG;
            end
            else
            begin
                fbc_next = fbc_next + 9'd1;
                if (fbc_next >= 9'd4)
                begin
                    res_next[n_res[1:0]] = mk_res(K_VERSION, 64'd2, '0, '0);
                    n_res = n_res + 3'd1;
                    mode_next = MODE_TAG;
                    fbc_next = '0;
                end
            end
        end

        if (!done && mode_next == MODE_SKIP)
        begin
            if (b == 8'd0)
                done = 1'b1;
            else
            begin
                step_next = step_next + 4'd1;
                mode_next = MODE_TAG;
                fbc_next = '0; acc_next = '0; ccnt_next = '0;
            end
        end

        if (!done && mode_next == MODE_TAG)
        begin
            done = 1'b1;
            if (step_next == STEP_TIME && off_next == '0 && fbc_next == '0 && b == 8'h36)
            begin
                mode_next = MODE_PREFIX;
                fbc_next = 9'd1;
            end
            else
            begin
                if (step_next == STEP_TIME && off_next == '0 && fbc_next == '0)
                begin
                    res_next[n_res[1:0]] = mk_res(K_VERSION, 64'd1, '0, '0);
                    n_res = n_res + 3'd1;
                end
                if (b != tag_char(step_next, fbc_next[1:0]))
                begin
                    if (err_next == ST_OK) err_next = ST_TAG;
                    step_next = STEP_END; mode_next = MODE_TAG;
                end
                else
                begin
                    fbc_next = fbc_next + 9'd1;
                    if (fbc_next >= 9'd4)
                    begin
                        mode_next = MODE_BODY;
                        fbc_next = '0; acc_next = '0; ccnt_next = '0;
                    end
                end
            end
        end

        if (!done && step_next == STEP_SYNC)
        begin
            done = 1'b1;
            if (fbc_next < 9'd4)
            begin
                acc_next = {acc_next[55:0], b};
                if (fbc_next == 9'd3)
                begin
                    if (acc_next[31:0] == TAG_SYNC && acc_next[63:32] == '0)
                        sk_next = SYNC_SYNC;
                    else if (acc_next[31:0] == TAG_SKEW && acc_next[63:32] == '0)
                        sk_next = SYNC_SKEW;
                    else
                        sk_next = SYNC_NONE;
                    acc_next = '0;
                end
            end
            else if (fbc_next < 9'd10)
            begin
                sts_next = {sts_next[39:0], b};
                if (b[7:4] > 4'd9 || b[3:0] > 4'd9) bok_next = 1'b0;
            end
            else
                acc_next = {32'd0, acc_next[23:0], b};
            fbc_next = fbc_next + 9'd1;
            if (fbc_next >= 9'd14)
            begin
                if (sk_next != SYNC_NONE && bok_next)
                begin
                    res_next[0] = mk_res(K_SYNCTYPE, {62'd0, sk_next}, '0, '0);
                    res_next[1] = mk_res(K_SYNCTIME, {16'd0, sts_next}, '0, '0);
                    res_next[2] = mk_res(K_SKEW, acc_next, '0, '0);
                end
                else
                begin
                    res_next[0] = mk_res(K_SYNCTYPE, '0, '0, '0);
                    res_next[1] = mk_res(K_SYNCTIME, '0, '0, '0);
                    res_next[2] = mk_res(K_SKEW, '0, '0, '0);
                end
                n_res = 3'd3;
                sk_next = SYNC_NONE; sts_next = '0; bok_next = 1'b1;
                step_next = STEP_ADDR; mode_next = MODE_TAG;
                fbc_next = '0; acc_next = '0; ccnt_next = '0;
            end
        end

        if (!done && step_next == STEP_GAIN)
        begin
            done = 1'b1;
            res_next[n_res[1:0]] = mk_res(K_GAIN, {56'd0, b}, fbc_next, '0);
            n_res = n_res + 3'd1;
            fbc_next = fbc_next + 9'd1;
            if (fbc_next >= {1'b0, ctot_next})
            begin
                step_next = STEP_BITD; mode_next = MODE_TAG;
                fbc_next = '0; acc_next = '0; ccnt_next = '0;
            end
        end

        if (!done && step_next <= STEP_BITD)
        begin
            done = 1'b1;
            acc_next = {acc_next[55:0], b};
            fbc_next = fbc_next + 9'd1;
            if (fbc_next >= {5'd0, num_len(step_next)})
            begin
                if (step_next == STEP_CHAN &&
                    (acc_next < 64'd1 || acc_next > 64'(MAX_CHANNELS)))
                begin
                    if (err_next == ST_OK) err_next = ST_CHANS;
                    step_next = STEP_END; mode_next = MODE_TAG;
                end
                else
                begin
                    if (step_next == STEP_CHAN) ctot_next = acc_next[7:0];
                    res_next[n_res[1:0]] = mk_res(num_kind(step_next), acc_next, '0, '0);
                    n_res = n_res + 3'd1;
                    step_next = step_next + 4'd1;
                    // sync block has no tag of its own
                    mode_next = (step_next == STEP_SYNC) ? MODE_BODY : MODE_TAG;
                    fbc_next = '0; acc_next = '0; ccnt_next = '0;
                end
            end
        end

        if (!done)
        begin
            if (b == 8'd0)
            begin
                fbc_next = '0;
                if (step_next == STEP_CMNT)
                begin
                    step_next = STEP_END; mode_next = MODE_TAG;
                end
                else if (step_next == STEP_ALIA)
                begin
                    ccnt_next = ccnt_next + 8'd1;
                    if (ccnt_next >= ctot_next) mode_next = MODE_SKIP;
                end
                else
                    mode_next = MODE_SKIP;
            end
            else if ({1'b0, fbc_next} + 10'd1 >= str_size)
            begin
                if (err_next == ST_OK) err_next = ST_STR_LONG;
                step_next = STEP_END; mode_next = MODE_TAG;
            end
            else
            begin
                res_next[n_res[1:0]] = mk_res({1'b0, step_next} + K_STR_OFS, {56'd0, b},
                    fbc_next, (step_next == STEP_ALIA) ? ccnt_next : 8'd0);
                n_res = n_res + 3'd1;
                fbc_next = fbc_next + 9'd1;
            end
        end

        if (last_byte)
        begin
            if (b != 8'd0)
                final_st = ST_LAST_NZ;
            else if (err_next != ST_OK)
                final_st = err_next;
            else if (step_next < STEP_END)
                final_st = ST_PAST_END;
            else
                final_st = ST_OK;
            res_next[n_res[1:0]] = mk_res(K_FINAL, '0, '0, '0);
            res_next[n_res[1:0]].status = final_st;
            res_next[n_res[1:0]].last_of_sector = 1'b1;
            n_res = n_res + 3'd1;
            off_next = '0; step_next = STEP_TIME; mode_next = MODE_TAG; fbc_next = '0;
            acc_next = '0; sts_next = '0; sk_next = SYNC_NONE; bok_next = 1'b1;
            ctot_next = '0; ccnt_next = '0; err_next = ST_OK;
        end
        else
            off_next = off_next + OFF_W'(1);
    end

    assign field_out.valid = (cnt_reg != 3'd0);
    assign take      = field_out.valid && field_out.ready;
    assign last_take = take && ({1'b0, pos_reg} + 3'd1 == cnt_reg);
    assign byte_in.ready = (cnt_reg == 3'd0) || last_take;
    assign accept    = byte_in.valid && byte_in.ready;

    assign field_out.field_kind     = res_reg[pos_reg].field_kind;
    assign field_out.value          = res_reg[pos_reg].value;
    assign field_out.item_index     = res_reg[pos_reg].item_index;
    assign field_out.channel_index  = res_reg[pos_reg].channel_index;
    assign field_out.status         = res_reg[pos_reg].status;
    assign field_out.last_of_sector = res_reg[pos_reg].last_of_sector;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0; step_reg <= STEP_TIME; mode_reg <= MODE_TAG; fbc_reg <= '0;
            acc_reg <= '0; sts_reg <= '0; sk_reg <= SYNC_NONE; bok_reg <= 1'b1;
            ctot_reg <= '0; ccnt_reg <= '0; err_reg <= ST_OK;
            cnt_reg <= '0; pos_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                off_reg <= off_next; step_reg <= step_next; mode_reg <= mode_next;
                fbc_reg <= fbc_next; acc_reg <= acc_next; sts_reg <= sts_next;
                sk_reg <= sk_next; bok_reg <= bok_next; ctot_reg <= ctot_next;
                ccnt_reg <= ccnt_next; err_reg <= err_next;
                cnt_reg <= n_res;
                pos_reg <= '0;
            end
            else if (last_take)
            begin
                cnt_reg <= '0;
                pos_reg <= '0;
            end
            else if (take)
                pos_reg <= pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        field_out.valid |-> ({1'b0, pos_reg} < cnt_reg))
        else $error("result position beyond bundle");
    a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
        off_reg <= OFF_LAST)
        else $error("offset beyond sector");
    a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (field_out.valid && field_out.last_of_sector) |-> field_out.field_kind == K_FINAL)
        else $error("last result is not final status");
    a_field_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (field_out.valid && !field_out.last_of_sector) |-> field_out.status == ST_OK)
        else $error("field result carries status");
    a_last_byte_final: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (off_reg == OFF_LAST) && !byte_in.sector_start) |=>
        res_reg[cnt_reg[1:0] - 2'd1].last_of_sector)
        else $error("final byte without final status");

endmodule
